// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PWTS_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define PWTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/pwts_pkg.sv
// ----------------------------------------------------------------------------
// pwts_pkg
// Types and fixed constants shared by the world-to-screen projection block.
// ----------------------------------------------------------------------------
package pwts_pkg;

  localparam int unsigned COORD_W   = 32;  // point and screen coordinate width
  localparam int unsigned CFG_W     = 64;  // widest config register
  localparam int unsigned CFG_IDX_W = 3;   // config register index width
  localparam int unsigned VP_W      = 14;  // viewport size width
  localparam int unsigned Q_BITS    = 41;  // quotient bits kept by the divider
  localparam int unsigned SUM_W     = 44;  // screen sum width before clamping

  // quotient magnitude cap, 2^40
  localparam logic [Q_BITS-1:0] Q_CAP = Q_BITS'(1) << (Q_BITS - 1);

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_X01 = 3'd0,
    REG_COL_X23 = 3'd1,
    REG_COL_Y01 = 3'd2,
    REG_COL_Y23 = 3'd3,
    REG_COL_W01 = 3'd4,
    REG_COL_W23 = 3'd5,
    REG_VP_W    = 3'd6,
    REG_VP_H    = 3'd7
  } reg_idx_e;

  // current configuration; each column word packs row 0/2 low, row 1/3 high
  typedef struct packed {
    logic [CFG_W-1:0] col_x01;
    logic [CFG_W-1:0] col_x23;
    logic [CFG_W-1:0] col_y01;
    logic [CFG_W-1:0] col_y23;
    logic [CFG_W-1:0] col_w01;
    logic [CFG_W-1:0] col_w23;
    logic [VP_W-1:0]  vp_w;
    logic [VP_W-1:0]  vp_h;
  } cfg_t;

endpackage

// File: hdl/pwts_front.sv
// ----------------------------------------------------------------------------
// pwts_front
// Front end: accepts points and forms the X, Y and W clip values in three
// stages (input register, nine products, floored sum).
// ----------------------------------------------------------------------------
module pwts_front #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned DotW = 67 - FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  pwts_pkg::cfg_t      cfg_i,
  output logic                valid_o,
  output logic signed [DotW-1:0] cx_o,
  output logic signed [DotW-1:0] cy_o,
  output logic signed [DotW-1:0] cw_o
);

  logic                   s0_valid_q, s1_valid_q, s2_valid_q;
  logic signed [31:0]     pt_q   [3];
  logic signed [31:0]     ent    [3][4];
  logic signed [63:0]     prod_d [3][3];
  logic signed [63:0]     prod_q [3][3];
  logic signed [DotW-1:0] dot_d  [3];
  logic signed [DotW-1:0] dot_q  [3];

  // matrix entries by column and row
  always_comb begin
    ent[0][0] = cfg_i.col_x01[31:0];
    ent[0][1] = cfg_i.col_x01[63:32];
    ent[0][2] = cfg_i.col_x23[31:0];
    ent[0][3] = cfg_i.col_x23[63:32];
    ent[1][0] = cfg_i.col_y01[31:0];
    ent[1][1] = cfg_i.col_y01[63:32];
    ent[1][2] = cfg_i.col_y23[31:0];
    ent[1][3] = cfg_i.col_y23[63:32];
    ent[2][0] = cfg_i.col_w01[31:0];
    ent[2][1] = cfg_i.col_w01[63:32];
    ent[2][2] = cfg_i.col_w23[31:0];
    ent[2][3] = cfg_i.col_w23[63:32];
  end

  // exact products, one 32x32 multiplier each
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_d[c][r] = pt_q[r] * ent[c][r];
      end
    end
  end

  // floor shift of each product, then exact sum with the row 3 entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dot_d[c] = DotW'(prod_q[c][0] >>> FRAC_BITS) + DotW'(prod_q[c][1] >>> FRAC_BITS)
               + DotW'(prod_q[c][2] >>> FRAC_BITS) + DotW'(ent[c][3]);
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s0_valid_q <= in_valid_i;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
      prod_q  <= prod_d;
      dot_q   <= dot_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign cx_o    = dot_q[0];
  assign cy_o    = dot_q[1];
  assign cw_o    = dot_q[2];

endmodule

// File: hdl/pwts_fifo.sv
// ----------------------------------------------------------------------------
// pwts_fifo
// Small register queue between front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwts_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  // pointers (wrap at DEPTH) and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);

  `PWTS_ASSERT(a_no_overflow, push_i, !full_o, "word pushed into full queue")
  `PWTS_ASSERT(a_no_underflow, pop_i, !empty_o, "word popped from empty queue")
  `PWTS_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count stuck")

endmodule

// File: hdl/pwts_back.sv
// ----------------------------------------------------------------------------
// pwts_back
// Back end: scales clip X and Y by the viewport size, divides by W in a
// one-bit-per-stage restoring divider, offsets, clamps and holds the result.
// ----------------------------------------------------------------------------
module pwts_back #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned DotW = 67 - FRAC_BITS,
  localparam int unsigned DenW = DotW - 1,
  localparam int unsigned ProdW = DotW + pwts_pkg::VP_W,
  localparam int unsigned NumW = ProdW + FRAC_BITS - 1,
  localparam int unsigned QB = pwts_pkg::Q_BITS,
  localparam int unsigned SumW = pwts_pkg::SUM_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [DotW-1:0]  cx_i,
  input  logic signed [DotW-1:0]  cy_i,
  input  logic signed [DotW-1:0]  cw_i,
  input  logic [pwts_pkg::VP_W-1:0] vp_w_i,
  input  logic [pwts_pkg::VP_W-1:0] vp_h_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [31:0]      screen_x_o,
  output logic signed [31:0]      screen_y_o,
  output logic                    visible_o,
  output logic                    saturated_o
);

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } flags_t;

  localparam logic signed [SumW-1:0] Max32 = (SumW'(1) << 31) - SumW'(1);
  localparam logic signed [SumW-1:0] Min32 = -(SumW'(1) << 31);

  logic be;

  // stage A: sign split and magnitudes
  logic             a_valid_q;
  flags_t           a_fl_q;
  logic [DotW-1:0]  a_mag_x_q, a_mag_y_q;
  logic [DenW-1:0]  a_den_q;

  // stage B: viewport scaling
  logic             b_valid_q;
  flags_t           b_fl_q;
  logic [ProdW-1:0] b_num_x_q, b_num_y_q;
  logic [DenW-1:0]  b_den_q;

  // divider rows
  logic             d_valid_q [QB+1];
  flags_t           d_fl_q    [QB+1];
  logic [DenW-1:0]  d_den_q   [QB+1];
  logic [DenW-1:0]  d_rx_q    [QB+1];
  logic [DenW-1:0]  d_ry_q    [QB+1];
  logic [QB-1:0]    d_qx_q    [QB+1];
  logic [QB-1:0]    d_qy_q    [QB+1];
  logic [QB-1:0]    d_nx_q    [QB+1];
  logic [QB-1:0]    d_ny_q    [QB+1];

  logic [DenW-1:0]  rx_d [QB];
  logic [DenW-1:0]  ry_d [QB];
  logic             bx_d [QB];
  logic             by_d [QB];

  // division setup
  logic [NumW-1:0]  n_x, n_y, hi_x, hi_y;
  flags_t           c_fl;

  // result
  logic [QB-1:0]          q_x, q_y;
  logic signed [SumW-1:0] t_x, t_y, off_x, off_y, s_x, s_y;
  logic signed [31:0]     c_x, c_y;
  logic                   sat_d;

  logic                   out_valid_q;
  logic signed [31:0]     sx_q, sy_q;
  logic                   vis_q, sat_q;

  assign be    = !out_valid_q || out_ready_i;
  assign pop_o = valid_i && be;

  // overflow test and first remainder: quotient >= 2^41 when N/2^41 >= W
  always_comb begin
    n_x  = NumW'(b_num_x_q) << (FRAC_BITS - 1);
    n_y  = NumW'(b_num_y_q) << (FRAC_BITS - 1);
    hi_x = n_x >> QB;
    hi_y = n_y >> QB;
    c_fl = b_fl_q;
    c_fl.ovf_x = (hi_x >= NumW'(b_den_q));
    c_fl.ovf_y = (hi_y >= NumW'(b_den_q));
  end

  // restoring division steps, one quotient bit per row
  always_comb begin
    for (int i = 0; i < QB; i++) begin
      logic [DenW:0] tx, ty;
      tx = {d_rx_q[i], d_nx_q[i][QB-1]};
      ty = {d_ry_q[i], d_ny_q[i][QB-1]};
      bx_d[i] = (tx >= {1'b0, d_den_q[i]});
      by_d[i] = (ty >= {1'b0, d_den_q[i]});
      rx_d[i] = bx_d[i] ? DenW'(tx - {1'b0, d_den_q[i]}) : tx[DenW-1:0];
      ry_d[i] = by_d[i] ? DenW'(ty - {1'b0, d_den_q[i]}) : ty[DenW-1:0];
    end
  end

  // cap, sign, offset and clamp
  always_comb begin
    q_x   = (d_fl_q[QB].ovf_x || d_qx_q[QB] > pwts_pkg::Q_CAP) ? pwts_pkg::Q_CAP : d_qx_q[QB];
    q_y   = (d_fl_q[QB].ovf_y || d_qy_q[QB] > pwts_pkg::Q_CAP) ? pwts_pkg::Q_CAP : d_qy_q[QB];
    t_x   = d_fl_q[QB].neg_x ? -signed'(SumW'(q_x)) : signed'(SumW'(q_x));
    t_y   = d_fl_q[QB].neg_y ? -signed'(SumW'(q_y)) : signed'(SumW'(q_y));
    off_x = signed'(SumW'(vp_w_i) << (FRAC_BITS - 1));
    off_y = signed'(SumW'(vp_h_i) << (FRAC_BITS - 1));
    s_x   = off_x + t_x;
    s_y   = off_y - t_y;
    sat_d = 1'b0;
    if (s_x > Max32) begin
      c_x = 32'sh7FFF_FFFF; sat_d = 1'b1;
    end else if (s_x < Min32) begin
      c_x = 32'sh8000_0000; sat_d = 1'b1;
    end else begin
      c_x = s_x[31:0];
    end
    if (s_y > Max32) begin
      c_y = 32'sh7FFF_FFFF; sat_d = 1'b1;
    end else if (s_y < Min32) begin
      c_y = 32'sh8000_0000; sat_d = 1'b1;
    end else begin
      c_y = s_y[31:0];
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= QB; i++) d_valid_q[i] <= 1'b0;
    end else if (be) begin
      a_valid_q    <= valid_i;
      b_valid_q    <= a_valid_q;
      d_valid_q[0] <= b_valid_q;
      for (int i = 0; i < QB; i++) d_valid_q[i+1] <= d_valid_q[i];
      out_valid_q  <= d_valid_q[QB];
    end
  end

  // payload chain
  always_ff @(posedge clk_i) begin
    if (be) begin
      a_fl_q.vis   <= (cw_i > 0);
      a_fl_q.neg_x <= cx_i[DotW-1];
      a_fl_q.neg_y <= cy_i[DotW-1];
      a_fl_q.ovf_x <= 1'b0;
      a_fl_q.ovf_y <= 1'b0;
      a_mag_x_q    <= cx_i[DotW-1] ? DotW'(-cx_i) : DotW'(cx_i);
      a_mag_y_q    <= cy_i[DotW-1] ? DotW'(-cy_i) : DotW'(cy_i);
      a_den_q      <= cw_i[DenW-1:0];

      b_fl_q    <= a_fl_q;
      b_num_x_q <= ProdW'(a_mag_x_q) * ProdW'(vp_w_i);
      b_num_y_q <= ProdW'(a_mag_y_q) * ProdW'(vp_h_i);
      b_den_q   <= a_den_q;

      d_fl_q[0]  <= c_fl;
      d_den_q[0] <= b_den_q;
      d_rx_q[0]  <= hi_x[DenW-1:0];
      d_ry_q[0]  <= hi_y[DenW-1:0];
      d_qx_q[0]  <= '0;
      d_qy_q[0]  <= '0;
      d_nx_q[0]  <= n_x[QB-1:0];
      d_ny_q[0]  <= n_y[QB-1:0];
      for (int i = 0; i < QB; i++) begin
        d_fl_q[i+1]  <= d_fl_q[i];
        d_den_q[i+1] <= d_den_q[i];
        d_rx_q[i+1]  <= rx_d[i];
        d_ry_q[i+1]  <= ry_d[i];
        d_qx_q[i+1]  <= {d_qx_q[i][QB-2:0], bx_d[i]};
        d_qy_q[i+1]  <= {d_qy_q[i][QB-2:0], by_d[i]};
        d_nx_q[i+1]  <= d_nx_q[i] << 1;
        d_ny_q[i+1]  <= d_ny_q[i] << 1;
      end

      // behind the camera: all fields zero
      vis_q <= d_fl_q[QB].vis;
      sx_q  <= d_fl_q[QB].vis ? c_x : '0;
      sy_q  <= d_fl_q[QB].vis ? c_y : '0;
      sat_q <= d_fl_q[QB].vis && sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign visible_o   = vis_q;
  assign saturated_o = sat_q;

endmodule

// File: hdl/perspective_world_to_screen.sv
// ----------------------------------------------------------------------------
// perspective_world_to_screen
// Projects world points through a view-projection matrix to screen pixels.
// ----------------------------------------------------------------------------
// Takes one point (x, y, z, signed fixed point with FRAC_BITS fraction bits)
// per cycle while in_ready_o is high and returns one screen word per point,
// in order: the front end forms clip X, Y and W, the point then passes a small
// queue and a back end of three setup stages, a 41-stage restoring divider
// (one quotient bit per stage, which sets the depth) and the output register.
// Sustained rate is one point per clock while the output is not stalled; a
// stalled output freezes the back end, and the queue then lets the front end
// keep going until it fills. Points with W <= 0 come out as not visible with
// zero coordinates; coordinates that leave the signed 32-bit range are clamped
// and flagged. Load the matrix columns and viewport through the write port only
// while no point is in flight.

module perspective_world_to_screen #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned DotW = 67 - FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pwts_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pwts_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [31:0]                point_x_i,
  input  logic signed [31:0]                point_y_i,
  input  logic signed [31:0]                point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                screen_x_o,
  output logic signed [31:0]                screen_y_o,
  output logic                              visible_o,
  output logic                              saturated_o
);

  localparam logic [63:0] One = 64'(1) << FRAC_BITS;

  pwts_pkg::cfg_t cfg_q;

  logic                  f_adv, f_valid;
  logic signed [DotW-1:0] f_cx, f_cy, f_cw;
  logic                  q_full, q_empty, q_pop;
  logic [3*DotW-1:0]     q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_x01 <= One;
      cfg_q.col_x23 <= '0;
      cfg_q.col_y01 <= One << 32;
      cfg_q.col_y23 <= '0;
      cfg_q.col_w01 <= '0;
      cfg_q.col_w23 <= One;
      cfg_q.vp_w    <= pwts_pkg::VP_W'(1920);
      cfg_q.vp_h    <= pwts_pkg::VP_W'(1080);
    end else if (cfg_we_i) begin
      case (pwts_pkg::reg_idx_e'(cfg_idx_i))
        pwts_pkg::REG_COL_X01: cfg_q.col_x01 <= cfg_data_i;
        pwts_pkg::REG_COL_X23: cfg_q.col_x23 <= cfg_data_i;
        pwts_pkg::REG_COL_Y01: cfg_q.col_y01 <= cfg_data_i;
        pwts_pkg::REG_COL_Y23: cfg_q.col_y23 <= cfg_data_i;
        pwts_pkg::REG_COL_W01: cfg_q.col_w01 <= cfg_data_i;
        pwts_pkg::REG_COL_W23: cfg_q.col_w23 <= cfg_data_i;
        pwts_pkg::REG_VP_W:    cfg_q.vp_w    <= cfg_data_i[pwts_pkg::VP_W-1:0];
        pwts_pkg::REG_VP_H:    cfg_q.vp_h    <= cfg_data_i[pwts_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  // front end moves unless its finished word cannot enter the queue
  assign f_adv      = !f_valid || !q_full;
  assign in_ready_o = f_adv;

  pwts_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (f_adv),
    .in_valid_i (in_valid_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .cfg_i      (cfg_q),
    .valid_o    (f_valid),
    .cx_o       (f_cx),
    .cy_o       (f_cy),
    .cw_o       (f_cw)
  );

  pwts_fifo #(
    .WIDTH (3 * DotW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .wdata_i ({f_cx, f_cy, f_cw}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pwts_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!q_empty),
    .cx_i        (q_rdata[3*DotW-1:2*DotW]),
    .cy_i        (q_rdata[2*DotW-1:DotW]),
    .cw_i        (q_rdata[DotW-1:0]),
    .vp_w_i      (cfg_q.vp_w),
    .vp_h_i      (cfg_q.vp_h),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .visible_o   (visible_o),
    .saturated_o (saturated_o)
  );

endmodule

// File: dv/perspective_world_to_screen_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_world_to_screen_tb
// Drives world points through the projection block under several matrix and
// viewport settings with random valid/ready gaps, and checks every screen
// word against a bit-exact fixed-point projection kept in the bench.
// ----------------------------------------------------------------------------
module perspective_world_to_screen_tb;

  localparam int unsigned Frac = 16;
  localparam int unsigned Latency = 80;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               vis;
    logic               sat;
  } screen_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [pwts_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pwts_pkg::CFG_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic signed [31:0] point_x_i, point_y_i, point_z_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic visible_o, saturated_o;

  perspective_world_to_screen #(.FRAC_BITS(Frac)) u_top (.*);

  // bench copy of the configuration
  logic [63:0] mat_regs [0:5];
  logic [13:0] vp_width, vp_height;

  point_t  pending_points[$];
  screen_t expected_screens[$];
  int      errors;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // floor shift of an exact product
  function automatic logic signed [127:0] floor_scale(logic signed [31:0] c,
                                                      logic signed [31:0] m);
    logic signed [127:0] p;
    p = 128'(c) * 128'(m);
    return p >>> Frac;
  endfunction

  function automatic logic signed [127:0] clip_dot(logic [63:0] c01, logic [63:0] c23,
                                                   point_t pt);
    return floor_scale(pt.px, c01[31:0]) + floor_scale(pt.py, c01[63:32])
         + floor_scale(pt.pz, c23[31:0]) + 128'(signed'(c23[63:32]));
  endfunction

  // truncated num*scale/den with magnitude capped at 2^40
  function automatic logic signed [127:0] capped_quot(logic signed [127:0] num,
                                                      logic [127:0] scale,
                                                      logic [127:0] den);
    logic [255:0] mag;
    logic [255:0] q;
    logic neg;
    neg = num < 0;
    mag = neg ? 256'(-num) : 256'(num);
    q = (mag * 256'(scale)) / 256'(den);
    if (q > (256'(1) << 40)) q = 256'(1) << 40;
    return neg ? -128'(q) : 128'(q);
  endfunction

  function automatic logic signed [31:0] clamp_coord(logic signed [127:0] v,
                                                     inout logic sat);
    if (v > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic screen_t project_point(point_t pt);
    screen_t r;
    logic signed [127:0] cx, cy, cw, sx, sy;
    logic sat;
    r = '0;
    sat = 1'b0;
    cx = clip_dot(mat_regs[pwts_pkg::REG_COL_X01], mat_regs[pwts_pkg::REG_COL_X23], pt);
    cy = clip_dot(mat_regs[pwts_pkg::REG_COL_Y01], mat_regs[pwts_pkg::REG_COL_Y23], pt);
    cw = clip_dot(mat_regs[pwts_pkg::REG_COL_W01], mat_regs[pwts_pkg::REG_COL_W23], pt);
    if (cw <= 0) return r;
    sx = (128'(vp_width) << (Frac - 1))
       + capped_quot(cx, 128'(vp_width) << Frac, 128'(cw) << 1);
    sy = (128'(vp_height) << (Frac - 1))
       - capped_quot(cy, 128'(vp_height) << Frac, 128'(cw) << 1);
    r.sx = clamp_coord(sx, sat);
    r.sy = clamp_coord(sy, sat);
    r.vis = 1'b1;
    r.sat = sat;
    return r;
  endfunction

  task automatic write_reg(pwts_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == pwts_pkg::REG_VP_W) vp_width = val[13:0];
    else if (idx == pwts_pkg::REG_VP_H) vp_height = val[13:0];
    else mat_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || in_valid_i || expected_screens.size() != 0)
      @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q_word(int unsigned whole);
    return 32'(whole) << Frac;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(signed'($urandom_range(0, 400)) - 200) << Frac
                      | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.px = rand_coord();
    p.py = rand_coord();
    p.pz = rand_coord();
    return p;
  endfunction

  // random perspective-like matrix, sometimes fully random words
  task automatic load_random_matrix(bit wild);
    logic [63:0] v;
    for (int i = 0; i < 6; i++) begin
      if (wild) v = {$urandom(), $urandom()};
      else v = {32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16)),
                32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16))};
      write_reg(pwts_pkg::reg_idx_e'(i), v);
    end
  endtask

  // driver: one word per accepted handshake, random gap before each
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      point_x_i <= '0;
      point_y_i <= '0;
      point_z_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_screens.push_back(project_point({point_x_i, point_y_i, point_z_i}));
        void'(pending_points.pop_front());
        send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (send_gap == 0 && pending_points.size() != 0 && $urandom_range(0, 1)) begin
          in_valid_i <= 1'b1;
          {point_x_i, point_y_i, point_z_i} <= pending_points[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_points.size() != 0) begin
        if (send_gap != 0) send_gap <= send_gap - 1;
        else begin
          in_valid_i <= 1'b1;
          {point_x_i, point_y_i, point_z_i} <= pending_points[0];
        end
      end
    end
  end

  // monitor: random ready stalls, compare with oldest expectation
  int unsigned recv_gap;
  screen_t exp_s;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_screens.size() == 0) begin
          $error("unexpected screen word");
          errors++;
        end else begin
          exp_s = expected_screens.pop_front();
          if (screen_x_o !== exp_s.sx) begin
            $error("screen_x exp %h got %h", exp_s.sx, screen_x_o);
            errors++;
          end
          if (screen_y_o !== exp_s.sy) begin
            $error("screen_y exp %h got %h", exp_s.sy, screen_y_o);
            errors++;
          end
          if (visible_o !== exp_s.vis) begin
            $error("visible exp %b got %b", exp_s.vis, visible_o);
            errors++;
          end
          if (saturated_o !== exp_s.sat) begin
            $error("saturated exp %b got %b", exp_s.sat, saturated_o);
            errors++;
          end
        end
        recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    point_t p;
    errors = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pwts_pkg::REG_COL_X01;
    cfg_data_i = '0;
    mat_regs[0] = 64'h0000_0000_0001_0000;
    mat_regs[1] = '0;
    mat_regs[2] = 64'h0001_0000_0000_0000;
    mat_regs[3] = '0;
    mat_regs[4] = '0;
    mat_regs[5] = 64'h0000_0000_0001_0000;
    vp_width = 14'd1920;
    vp_height = 14'd1080;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset matrix: field extremes, behind camera, saturation
    pending_points.push_back('{32'h0, 32'h0, 32'h0});
    pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h0});
    pending_points.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_points.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    pending_points.push_back('{q_word(1), q_word(1), q_word(1)});
    wait_drained();

    // W from z: negative z is behind the camera, zero W too
    write_reg(pwts_pkg::REG_COL_W01, 64'h0);
    write_reg(pwts_pkg::REG_COL_W23, {32'h0, q_word(1)});
    write_reg(pwts_pkg::REG_COL_X23, 64'h0);
    write_reg(pwts_pkg::REG_COL_Y23, 64'h0);
    pending_points.push_back('{q_word(5), q_word(3), 32'hFFFF0000});
    pending_points.push_back('{q_word(5), q_word(3), 32'h0});
    pending_points.push_back('{q_word(5), q_word(3), 32'h1});
    pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h1});
    pending_points.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h1});
    pending_points.push_back('{q_word(2), 32'hFFFE0000, q_word(4)});
    wait_drained();

    // viewport extremes, including zero and the max written width, then extreme matrix words
    write_reg(pwts_pkg::REG_VP_W, 64'd1);
    write_reg(pwts_pkg::REG_VP_H, 64'd8192);
    pending_points.push_back('{q_word(1), q_word(1), q_word(2)});
    pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h1});
    wait_drained();
    write_reg(pwts_pkg::REG_VP_W, 64'h3FFF);
    write_reg(pwts_pkg::REG_VP_H, 64'h0);
    pending_points.push_back('{q_word(1), q_word(1), q_word(2)});
    pending_points.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h1});
    wait_drained();
    write_reg(pwts_pkg::REG_COL_X01, {64{1'b1}});
    write_reg(pwts_pkg::REG_COL_Y01, 64'h8000_0000_7FFF_FFFF);
    write_reg(pwts_pkg::REG_COL_W23, 64'h7FFF_FFFF_7FFF_FFFF);
    pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
    pending_points.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
    wait_drained();

    // random phases, each under its own configuration
    for (int ph = 0; ph < 11; ph++) begin
      load_random_matrix(ph % 3 == 2);
      if (ph % 4 == 0)
        write_reg(pwts_pkg::REG_COL_W23, {$urandom_range(1, 200) << 16, $urandom()});
      write_reg(pwts_pkg::REG_VP_W, ph == 3 ? 64'd8192 : 64'($urandom_range(1, 8192)));
      write_reg(pwts_pkg::REG_VP_H, ph == 4 ? 64'd1 : 64'($urandom_range(1, 8192)));
      for (int i = 0; i < 100; i++) begin
        p = rand_point();
        pending_points.push_back(p);
      end
      wait_drained();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
